>>> hdl/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg
// Shared types, codes and helpers of the daily alarm table unit.
// ----------------------------------------------------------------------------
package dat_pkg;

   localparam int ID_W      = 28;
   localparam int TIME_W    = 11;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int PAYLOAD_W = 16;
   localparam int LOW_W     = 17;
   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 2;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_HM  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_ID  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RETIME     = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        at;      // this cell sits at the edit position
      logic        beyond;  // this cell sits past the edit position
   } cell_ctl_type;

   typedef struct packed {
      logic hit;       // key found in the table
      logic tick_hit;  // some entry at or after now
   } scan_flags_type;

   function automatic logic [ID_W-1:0] pack_id(input logic [HOUR_W-1:0]   h,
                                                input logic [MINUTE_W-1:0] m,
                                                input logic [LOW_W-1:0]    low);
      pack_id = {h, m, low};
   endfunction

endpackage

>>> hdl/dat_cell.sv
// ----------------------------------------------------------------------------
// dat_cell
// One table slot: holds an identifier and trades it with its neighbours.
// ----------------------------------------------------------------------------
module dat_cell (
   input  logic                              clock,
   input  dat_pkg::cell_ctl_type             ctl,
   input  logic [dat_pkg::ID_W-1:0]          prev_id,
   input  logic [dat_pkg::ID_W-1:0]          next_id,
   input  logic [dat_pkg::ID_W-1:0]          ins_id,
   output logic [dat_pkg::ID_W-1:0]          id_out
);

   logic [dat_pkg::ID_W-1:0] id_ff;
   logic [dat_pkg::ID_W-1:0] id_in;

   always_comb begin
      id_in = id_ff;
      case (ctl.op)
         dat_pkg::CELL_ROTATE: begin
            id_in = next_id;
         end
         dat_pkg::CELL_INSERT: begin
            if (ctl.beyond) begin
               id_in = prev_id;
            end else if (ctl.at) begin
               id_in = ins_id;
            end
         end
         dat_pkg::CELL_DELETE: begin
            if (ctl.at || ctl.beyond) begin
               id_in = next_id;
            end
         end
         default: begin
            id_in = id_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out = id_ff;

endmodule

>>> hdl/dat_scan.sv
// ----------------------------------------------------------------------------
// dat_scan
// Head-of-row scanner: watches entries stream past and gathers lookups.
// ----------------------------------------------------------------------------
module dat_scan #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             step,
   input  logic [dat_pkg::ID_W-1:0]         head_id,
   input  logic [IDX_W-1:0]                 head_idx,
   input  logic [CNT_W-1:0]                 count,
   input  logic [dat_pkg::ID_W-1:0]         key,
   input  logic [dat_pkg::TIME_W-1:0]       now,
   output dat_pkg::scan_flags_type          flags,
   output logic [IDX_W-1:0]                 hit_idx,
   output logic [dat_pkg::ID_W-1:0]         hit_id,
   output logic [CNT_W-1:0]                 le_cnt,
   output logic [dat_pkg::ID_W-1:0]         tick_id
);

   dat_pkg::scan_flags_type flags_ff, flags_in;
   logic [CNT_W-1:0]        le_cnt_ff, le_cnt_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [dat_pkg::ID_W-1:0] hit_id_ff, hit_id_in;
   logic [dat_pkg::ID_W-1:0] cand_id_ff, cand_id_in;
   logic [dat_pkg::ID_W-1:0] first_id_ff, first_id_in;
   logic                    live;

   // only entries below the fill count take part
   assign live = step && (CNT_W'(head_idx) < count);

   always_comb begin
      flags_in    = flags_ff;
      le_cnt_in   = le_cnt_ff;
      hit_idx_in  = hit_idx_ff;
      hit_id_in   = hit_id_ff;
      cand_id_in  = cand_id_ff;
      first_id_in = first_id_ff;
      if (clear) begin
         flags_in  = '0;
         le_cnt_in = '0;
      end else if (live) begin
         if (!flags_ff.hit && head_id == key) begin
            flags_in.hit = 1'b1;
            hit_idx_in   = head_idx;
            hit_id_in    = head_id;
         end
         if (head_id <= key) begin
            le_cnt_in = le_cnt_ff + CNT_W'(1);
         end
         if (head_idx == '0) begin
            first_id_in = head_id;
         end
         if (!flags_ff.tick_hit &&
             head_id[dat_pkg::ID_W-1 -: dat_pkg::TIME_W] >= now) begin
            flags_in.tick_hit = 1'b1;
            cand_id_in        = head_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= '0;
         le_cnt_ff <= '0;
      end else begin
         flags_ff  <= flags_in;
         le_cnt_ff <= le_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      hit_id_ff   <= hit_id_in;
      cand_id_ff  <= cand_id_in;
      first_id_ff <= first_id_in;
   end

   assign flags   = flags_ff;
   assign hit_idx = hit_idx_ff;
   assign hit_id  = hit_id_ff;
   assign le_cnt  = le_cnt_ff;
   // wrap to the first entry when nothing lies at or after now
   assign tick_id = flags_ff.tick_hit ? cand_id_ff : first_id_ff;

endmodule

>>> hdl/daily_alarm_table_unit.sv
// a request runs a scan pass (the cell row rotates once past the single head
//   scanner), a decide step and a hand-over to the output register; a retime
//   that finds its entry makes a second pass to re-insert it
// a new request is taken only in idle, after the last has been handed over
// reset: fill count and last-fired mark cleared, cell contents left as they are
// ----------------------------------------------------------------------------
// daily_alarm_table_unit
// Sorted table of daily alarms held in a row of cells; ticks fire due alarms.
// ----------------------------------------------------------------------------
module daily_alarm_table_unit #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dat_pkg::FUNC_W-1:0]          req_func,
   input  logic [dat_pkg::HOUR_W-1:0]          req_hours,
   input  logic [dat_pkg::MINUTE_W-1:0]        req_minutes,
   input  logic [dat_pkg::PAYLOAD_W-1:0]       req_payload,
   input  logic [dat_pkg::ID_W-1:0]            req_entry_id,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dat_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_fire,
   output logic [dat_pkg::PAYLOAD_W-1:0]       rsp_fire_payload,
   output logic [dat_pkg::ID_W-1:0]            rsp_new_id
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // sequencer state
   dat_pkg::state_type              state_ff, state_in;
   logic                            phase2_ff, phase2_in;   // retime re-insert pass
   logic [IDX_W-1:0]                scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [dat_pkg::ID_W-1:0]        last_fired_ff, last_fired_in;

   // request held for the duration of the work
   logic [dat_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [dat_pkg::TIME_W-1:0]      now_ff, now_in;
   logic [dat_pkg::ID_W-1:0]        key_ff, key_in;

   // finished result, waiting for the output register
   logic [dat_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                            res_fire_ff, res_fire_in;
   logic [dat_pkg::PAYLOAD_W-1:0]   res_payload_ff, res_payload_in;
   logic [dat_pkg::ID_W-1:0]        res_new_id_ff, res_new_id_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dat_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                            rsp_fire_ff, rsp_fire_in;
   logic [dat_pkg::PAYLOAD_W-1:0]   rsp_payload_ff, rsp_payload_in;
   logic [dat_pkg::ID_W-1:0]        rsp_new_id_ff, rsp_new_id_in;

   // cell row and scanner hookup
   logic [dat_pkg::ID_W-1:0]        cell_id [ENTRIES];
   dat_pkg::cell_op_type            row_op;
   logic [CNT_W-1:0]                edit_pos;
   logic                            scan_clear;
   logic                            scan_step;
   dat_pkg::scan_flags_type         scan_flags;
   logic [IDX_W-1:0]                scan_hit_idx;
   logic [dat_pkg::ID_W-1:0]        scan_hit_id;
   logic [CNT_W-1:0]                scan_le_cnt;
   logic [dat_pkg::ID_W-1:0]        scan_tick_id;
   logic                            tick_due;
   logic                            out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tick_due = scan_tick_id[dat_pkg::ID_W-1 -: dat_pkg::TIME_W] == now_ff;

   // ------------------------------------------------------------------------
   // sequencer: scan pass (row rotates once past the head), a decide step that
   // applies the edit (a found retime scans again), hand over to output register
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      phase2_in      = phase2_ff;
      scan_idx_in    = scan_idx_ff;
      count_in       = count_ff;
      last_fired_in  = last_fired_ff;
      func_in        = func_ff;
      now_in         = now_ff;
      key_in         = key_ff;
      res_status_in  = res_status_ff;
      res_fire_in    = res_fire_ff;
      res_payload_in = res_payload_ff;
      res_new_id_in  = res_new_id_ff;
      row_op         = dat_pkg::CELL_HOLD;
      edit_pos       = '0;
      scan_clear     = 1'b0;
      scan_step      = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         dat_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in     = req_func;
               now_in      = {req_hours, req_minutes};
               // insert by time packs its own key, the rest look up by id
               key_in      = (req_func == dat_pkg::FUNC_INSERT_HM) ?
                             dat_pkg::pack_id(req_hours, req_minutes,
                                              {1'b0, req_payload}) :
                             req_entry_id;
               phase2_in   = 1'b0;
               scan_idx_in = '0;
               scan_clear  = 1'b1;
               state_in    = dat_pkg::ST_SCAN;
            end
         end

         dat_pkg::ST_SCAN: begin
            row_op      = dat_pkg::CELL_ROTATE;
            scan_step   = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
               scan_idx_in = '0;
               state_in    = dat_pkg::ST_DECIDE;
            end
         end

         dat_pkg::ST_DECIDE: begin
            res_status_in  = dat_pkg::STATUS_OK;
            res_fire_in    = 1'b0;
            res_payload_in = '0;
            res_new_id_in  = '0;
            state_in       = dat_pkg::ST_DONE;
            if (phase2_ff) begin
               // second half of a retime: slot the new id in after equals
               row_op        = dat_pkg::CELL_INSERT;
               edit_pos      = scan_le_cnt;
               count_in      = count_ff + CNT_W'(1);
               res_new_id_in = key_ff;
            end else begin
               case (func_ff)
                  dat_pkg::FUNC_TICK: begin
                     if (count_ff != '0) begin
                        if (tick_due && last_fired_ff != scan_tick_id) begin
                           res_fire_in    = 1'b1;
                           res_payload_in = scan_tick_id[dat_pkg::PAYLOAD_W-1:0];
                           last_fired_in  = scan_tick_id;
                        end else if (!tick_due && last_fired_ff == scan_tick_id) begin
                           last_fired_in = '0;
                        end
                     end
                  end
                  dat_pkg::FUNC_INSERT_HM,
                  dat_pkg::FUNC_INSERT_ID: begin
                     // duplicate takes precedence over full
                     if (scan_flags.hit) begin
                        res_status_in = dat_pkg::STATUS_DUPLICATE;
                     end else if (count_ff == CNT_W'(ENTRIES)) begin
                        res_status_in = dat_pkg::STATUS_FULL;
                     end else begin
                        row_op   = dat_pkg::CELL_INSERT;
                        edit_pos = scan_le_cnt;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  dat_pkg::FUNC_REMOVE: begin
                     if (scan_flags.hit) begin
                        row_op   = dat_pkg::CELL_DELETE;
                        edit_pos = CNT_W'(scan_hit_idx);
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        res_status_in = dat_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  dat_pkg::FUNC_RETIME: begin
                     if (scan_flags.hit) begin
                        // pull the entry out now, re-insert after another pass;
                        // bit 16 of the old id is dropped
                        row_op      = dat_pkg::CELL_DELETE;
                        edit_pos    = CNT_W'(scan_hit_idx);
                        count_in    = count_ff - CNT_W'(1);
                        key_in      = dat_pkg::pack_id(
                                         now_ff[dat_pkg::TIME_W-1 -: dat_pkg::HOUR_W],
                                         now_ff[dat_pkg::MINUTE_W-1:0],
                                         {1'b0, scan_hit_id[dat_pkg::PAYLOAD_W-1:0]});
                        phase2_in   = 1'b1;
                        scan_clear  = 1'b1;
                        state_in    = dat_pkg::ST_SCAN;
                     end else begin
                        res_status_in = dat_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     // unused codes: all-zero result, table untouched
                     res_status_in = dat_pkg::STATUS_OK;
                  end
               endcase
            end
         end

         dat_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = dat_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dat_pkg::ST_IDLE;
         end
      endcase
   end

   // output register: loads from the held result, drains on a taken beat
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_fire_in    = rsp_fire_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_new_id_in  = rsp_new_id_ff;
      if (state_ff == dat_pkg::ST_DONE && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_fire_in    = res_fire_ff;
         rsp_payload_in = res_payload_ff;
         rsp_new_id_in  = res_new_id_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dat_pkg::ST_IDLE;
         phase2_ff     <= 1'b0;
         scan_idx_ff   <= '0;
         count_ff      <= '0;
         last_fired_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase2_ff     <= phase2_in;
         scan_idx_ff   <= scan_idx_in;
         count_ff      <= count_in;
         last_fired_ff <= last_fired_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      now_ff         <= now_in;
      key_ff         <= key_in;
      res_status_ff  <= res_status_in;
      res_fire_ff    <= res_fire_in;
      res_payload_ff <= res_payload_in;
      res_new_id_ff  <= res_new_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_fire_ff    <= rsp_fire_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_new_id_ff  <= rsp_new_id_in;
   end

   // ------------------------------------------------------------------------
   // cell row: cell 0 is the head; rotation moves every entry one place
   // toward the head, the head wrapping round to the tail
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      dat_pkg::cell_ctl_type    ctl;
      logic [dat_pkg::ID_W-1:0] prev_id;
      logic [dat_pkg::ID_W-1:0] next_id;

      assign ctl.op     = row_op;
      assign ctl.at     = (edit_pos == CNT_W'(i));
      assign ctl.beyond = (CNT_W'(i) > edit_pos);

      if (i == 0) begin : g_first
         assign prev_id = key_ff;
      end else begin : g_prev
         assign prev_id = cell_id[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign next_id = cell_id[0];
      end else begin : g_next
         assign next_id = cell_id[i+1];
      end

      dat_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .prev_id (prev_id),
         .next_id (next_id),
         .ins_id  (key_ff),
         .id_out  (cell_id[i])
      );
   end

   // head scanner
   dat_scan #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (scan_clear),
      .step     (scan_step),
      .head_id  (cell_id[0]),
      .head_idx (scan_idx_ff),
      .count    (count_ff),
      .key      (key_ff),
      .now      (now_ff),
      .flags    (scan_flags),
      .hit_idx  (scan_hit_idx),
      .hit_id   (scan_hit_id),
      .le_cnt   (scan_le_cnt),
      .tick_id  (scan_tick_id)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fire         = rsp_fire_ff;
   assign rsp_fire_payload = rsp_payload_ff;
   assign rsp_new_id       = rsp_new_id_ff;

endmodule
